// ===== rtl/mbtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtcp_pkg
// Shared types and constants for the Modbus TCP register server.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

    // item kinds on the input tuser
    localparam logic [1:0] IN_STREAM    = 2'd0;
    localparam logic [1:0] IN_WORD_WR   = 2'd1;
    localparam logic [1:0] IN_WORD_RD   = 2'd2;
    localparam logic [1:0] IN_BIT_WR    = 2'd3;

    // Modbus function codes
    localparam logic [7:0] FC_READ_HOLD  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT = 8'd4;
    localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
    localparam logic [7:0] FC_WRITE_MANY = 8'd16;

    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [7:0] EXC_BAD_FUNC  = 8'd1;
    localparam logic [7:0] EXC_BAD_VALUE = 8'd3;

    localparam logic [15:0] READ_MAX     = 16'd125;

    // result kinds on the output tuser
    localparam logic OUT_NET   = 1'b0;
    localparam logic OUT_LOCAL = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCAL,
        S_FINISH,
        S_HDR,
        S_FETCH,
        S_WAIT,
        S_HI,
        S_LO,
        S_DRAIN
    } state_t;

endpackage

// ===== rtl/mbtcp_ram.sv =====
// ----------------------------------------------------------------------------
// mbtcp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbtcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/modbus_tcp_register_server.sv =====
// ----------------------------------------------------------------------------
// modbus_tcp_register_server
// Modbus TCP holding-register server with local register access.
// ----------------------------------------------------------------------------
// After reset the block clears its register store, one entry per cycle,
// and accepts no item until that is done. A stream byte that does not end a
// frame leaves the block idle, so such bytes can follow back to back. A local
// access reads the store, writes the new word back unless it is a read or
// out of range, sends its reply and waits until the reply is taken. At frame
// end the response, if the frame is long enough to answer, is built one byte
// per cycle into 8-byte chunks while the output register is free; no byte is
// packed while a full chunk waits in the output register. Each register read
// passes through fetch and memory wait states before its two bytes, on the
// single store read port, and the input is held until the response has been
// sent.
module modbus_tcp_register_server
    import mbtcp_pkg::*;
#(
    parameter int REG_COUNT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // stream_byte, reg_address, reg_value, bit_index, bit_value
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // chunk_data, chunk_bytes, local_data, local_ok
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);
    localparam logic [AW-1:0] CLR_LAST = AW'(REG_COUNT - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]  clr_reg, clr_next;
    logic [16:0]    pos_reg, pos_next;
    logic [15:0]    trans_reg, trans_next;
    logic [15:0]    flen_reg, flen_next;
    logic [7:0]     unit_reg, unit_next;
    logic [7:0]     code_reg, code_next;
    logic [15:0]    ff_reg, ff_next;
    logic [15:0]    fs_reg, fs_next;
    logic [7:0]     dcnt_reg, dcnt_next;
    logic [7:0]     phigh_reg, phigh_next;
    logic           wall_reg, wall_next;

    // latched local access
    logic [1:0]     lfunc_reg, lfunc_next;
    logic [15:0]    laddr_reg, laddr_next;
    logic [15:0]    lval_reg, lval_next;
    logic [3:0]     lbit_reg, lbit_next;
    logic           lbv_reg, lbv_next;

    // response builder
    logic [7:0]     resp7_reg, resp7_next;
    logic [7:0]     resp8_reg, resp8_next;
    logic [7:0]     plen_reg, plen_next;
    logic           echo_reg, echo_next;
    logic           rdmode_reg, rdmode_next;
    logic [3:0]     hend_reg, hend_next;
    logic [3:0]     idx_reg, idx_next;
    logic [6:0]     rdi_reg, rdi_next;
    logic [15:0]    rda_reg, rda_next;
    logic [15:0]    word_reg, word_next;

    // output register / chunk packer
    logic           ov_reg, ov_next;
    logic           okind_reg, okind_next;
    logic [63:0]    chunk_reg, chunk_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           olast_reg, olast_next;
    logic [15:0]    ldata_reg, ldata_next;
    logic           lok_reg, lok_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [15:0]    ram_wdata, ram_rdata;

    mbtcp_ram #(.WIDTH(16), .DEPTH(REG_COUNT), .AW(AW)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [1:0]  in_func;
    logic [7:0]  in_byte;
    logic [15:0] in_addr;
    logic [15:0] in_val;
    logic [3:0]  in_bit;
    logic        in_bv;

    assign in_func = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_addr = s_tdata[23:8];
    assign in_val  = s_tdata[39:24];
    assign in_bit  = s_tdata[43:40];
    assign in_bv   = s_tdata[44];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'd0, lok_reg, ldata_reg, cnt_reg, chunk_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pos_reg    <= '0;
            trans_reg  <= '0;
            flen_reg   <= '0;
            unit_reg   <= '0;
            code_reg   <= '0;
            ff_reg     <= '0;
            fs_reg     <= '0;
            dcnt_reg   <= '0;
            phigh_reg  <= '0;
            wall_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            rdi_reg    <= '0;
            rdmode_reg <= 1'b0;
            hend_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pos_reg    <= pos_next;
            trans_reg  <= trans_next;
            flen_reg   <= flen_next;
            unit_reg   <= unit_next;
            code_reg   <= code_next;
            ff_reg     <= ff_next;
            fs_reg     <= fs_next;
            dcnt_reg   <= dcnt_next;
            phigh_reg  <= phigh_next;
            wall_reg   <= wall_next;
            ov_reg     <= ov_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            rdi_reg    <= rdi_next;
            rdmode_reg <= rdmode_next;
            hend_reg   <= hend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lfunc_reg <= lfunc_next;
        laddr_reg <= laddr_next;
        lval_reg  <= lval_next;
        lbit_reg  <= lbit_next;
        lbv_reg   <= lbv_next;
        resp7_reg <= resp7_next;
        resp8_reg <= resp8_next;
        plen_reg  <= plen_next;
        echo_reg  <= echo_next;
        rda_reg   <= rda_next;
        word_reg  <= word_next;
        okind_reg <= okind_next;
        chunk_reg <= chunk_next;
        olast_reg <= olast_next;
        ldata_reg <= ldata_next;
        lok_reg   <= lok_next;
    end

    logic [15:0] flen_cur;
    logic [16:0] fsize;
    logic [16:0] widx;
    logic [15:0] waddr16;
    logic        emit;
    logic [7:0]  ebyte;
    logic        elast;
    logic [15:0] lword;
    logic        lok;
    logic [15:0] mask;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        trans_next  = trans_reg;
        flen_next   = flen_reg;
        unit_next   = unit_reg;
        code_next   = code_reg;
        ff_next     = ff_reg;
        fs_next     = fs_reg;
        dcnt_next   = dcnt_reg;
        phigh_next  = phigh_reg;
        wall_next   = wall_reg;
        lfunc_next  = lfunc_reg;
        laddr_next  = laddr_reg;
        lval_next   = lval_reg;
        lbit_next   = lbit_reg;
        lbv_next    = lbv_reg;
        resp7_next  = resp7_reg;
        resp8_next  = resp8_reg;
        plen_next   = plen_reg;
        echo_next   = echo_reg;
        rdmode_next = rdmode_reg;
        hend_next   = hend_reg;
        idx_next    = idx_reg;
        rdi_next    = rdi_reg;
        rda_next    = rda_reg;
        word_next   = word_reg;
        ov_next     = ov_reg;
        okind_next  = okind_reg;
        chunk_next  = chunk_reg;
        cnt_next    = cnt_reg;
        olast_next  = olast_reg;
        ldata_next  = ldata_reg;
        lok_next    = lok_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        ram_raddr = laddr_reg[AW-1:0];

        flen_cur = flen_reg;
        fsize    = 17'(flen_reg) + 17'd6;
        widx     = (pos_reg - 17'd14) >> 1;
        waddr16  = ff_reg + widx[15:0];
        emit     = 1'b0;
        ebyte    = '0;
        elast    = 1'b0;
        lok      = ({1'b0, laddr_reg} < REG_LIMIT);
        mask     = 16'(1) << lbit_reg;
        lword    = ram_rdata;

        if (ov_reg && m_tready)
        begin
            ov_next    = 1'b0;
            cnt_next   = '0;
            chunk_next = '0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                ram_raddr = in_addr[AW-1:0];
                if (s_tvalid)
                begin
                    if (in_func != IN_STREAM)
                    begin
                        lfunc_next = in_func;
                        laddr_next = in_addr;
                        lval_next  = in_val;
                        lbit_next  = in_bit;
                        lbv_next   = in_bv;
                        state_next = S_LOCAL;
                    end
                    else
                    begin
                        case (pos_reg)
                            17'd0:
                            begin
                                trans_next = {in_byte, 8'd0};
                                wall_next  = 1'b0;
                            end
                            17'd1: trans_next = {trans_reg[15:8], in_byte};
                            17'd4: flen_next = {in_byte, 8'd0};
                            17'd5:
                            begin
                                flen_next = {flen_reg[15:8], in_byte};
                                flen_cur  = {flen_reg[15:8], in_byte};
                            end
                            17'd6: unit_next = in_byte;
                            17'd7: code_next = in_byte;
                            17'd8: ff_next = {in_byte, 8'd0};
                            17'd9: ff_next = {ff_reg[15:8], in_byte};
                            17'd10: fs_next = {in_byte, 8'd0};
                            17'd11: fs_next = {fs_reg[15:8], in_byte};
                            17'd12:
                            begin
                                dcnt_next = in_byte;
                                wall_next = (17'd13 + 17'(in_byte)) <= fsize;
                            end
                            default:
                            begin
                                if (pos_reg >= 17'd13)
                                begin
                                    if (pos_reg[0])
                                    begin
                                        phigh_next = in_byte;
                                    end
                                    else if (wall_reg && code_reg == FC_WRITE_MANY
                                             && widx < 17'(fs_reg)
                                             && {1'b0, waddr16} < REG_LIMIT)
                                    begin
                                        ram_we    = 1'b1;
                                        ram_waddr = waddr16[AW-1:0];
                                        ram_wdata = {phigh_reg, in_byte};
                                    end
                                end
                            end
                        endcase
                        if (pos_reg >= 17'd5 && pos_reg == 17'd5 + 17'(flen_cur))
                        begin
                            pos_next   = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            pos_next = pos_reg + 17'd1;
                        end
                    end
                end
            end

            S_LOCAL:
            begin
                case (lfunc_reg)
                    IN_WORD_WR: lword = lval_reg;
                    IN_BIT_WR:  lword = lbv_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
                    default:    lword = ram_rdata;
                endcase
                if (lok && lfunc_reg != IN_WORD_RD)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = laddr_reg[AW-1:0];
                    ram_wdata = lword;
                end
                ov_next    = 1'b1;
                okind_next = OUT_LOCAL;
                chunk_next = '0;
                cnt_next   = '0;
                olast_next = 1'b0;
                ldata_next = lok ? lword : 16'd0;
                lok_next   = lok;
                state_next = S_DRAIN;
            end

            S_FINISH:
            begin
                idx_next    = '0;
                rdi_next    = '0;
                rda_next    = ff_reg;
                rdmode_next = 1'b0;
                echo_next   = 1'b0;
                hend_next   = 4'd9;
                resp7_next  = code_reg | EXC_FLAG;
                resp8_next  = EXC_BAD_FUNC;
                plen_next   = 8'd3;
                state_next  = S_HDR;
                if (fsize < 17'd9)
                begin
                    state_next = S_IDLE;
                end
                else if (code_reg == FC_READ_HOLD || code_reg == FC_READ_INPUT)
                begin
                    if (fsize < 17'd12)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (fs_reg == 16'd0 || fs_reg > READ_MAX)
                    begin
                        resp8_next = EXC_BAD_VALUE;
                    end
                    else
                    begin
                        resp7_next  = code_reg;
                        resp8_next  = {fs_reg[6:0], 1'b0};
                        plen_next   = 8'd3 + {fs_reg[6:0], 1'b0};
                        rdmode_next = 1'b1;
                    end
                end
                else if (code_reg == FC_WRITE_ONE || code_reg == FC_WRITE_MANY)
                begin
                    resp7_next = code_reg;
                    echo_next  = 1'b1;
                    hend_next  = 4'd12;
                    plen_next  = 8'd6;
                    if (code_reg == FC_WRITE_ONE)
                    begin
                        if (fsize < 17'd12)
                        begin
                            state_next = S_IDLE;
                        end
                        else if ({1'b0, ff_reg} < REG_LIMIT)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ff_reg[AW-1:0];
                            ram_wdata = fs_reg;
                        end
                    end
                    else if (fsize < 17'd13 || (17'd13 + 17'(dcnt_reg)) > fsize)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_HDR:
            begin
                emit = !ov_reg;
                case (idx_reg)
                    4'd0:  ebyte = trans_reg[15:8];
                    4'd1:  ebyte = trans_reg[7:0];
                    4'd5:  ebyte = plen_reg;
                    4'd6:  ebyte = unit_reg;
                    4'd7:  ebyte = resp7_reg;
                    4'd8:  ebyte = echo_reg ? ff_reg[15:8] : resp8_reg;
                    4'd9:  ebyte = ff_reg[7:0];
                    4'd10: ebyte = fs_reg[15:8];
                    4'd11: ebyte = fs_reg[7:0];
                    default: ebyte = 8'd0;
                endcase
                elast = !rdmode_reg && (idx_reg == hend_reg - 4'd1);
                if (emit)
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == hend_reg - 4'd1)
                    begin
                        state_next = rdmode_reg ? S_FETCH : S_DRAIN;
                    end
                end
            end

            S_FETCH:
            begin
                ram_raddr  = rda_reg[AW-1:0];
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                word_next  = ({1'b0, rda_reg} < REG_LIMIT) ? ram_rdata : 16'd0;
                state_next = S_HI;
            end

            S_HI:
            begin
                emit  = !ov_reg;
                ebyte = word_reg[15:8];
                if (emit)
                begin
                    state_next = S_LO;
                end
            end

            S_LO:
            begin
                emit  = !ov_reg;
                ebyte = word_reg[7:0];
                elast = ({9'd0, rdi_reg} == fs_reg - 16'd1);
                if (emit)
                begin
                    if (elast)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rdi_next   = rdi_reg + 7'd1;
                        rda_next   = rda_reg + 16'd1;
                        state_next = S_FETCH;
                    end
                end
            end

            S_DRAIN:
            begin
                if (!ov_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // byte packer: fill from the top, ship when full or on the final byte
        if (emit)
        begin
            chunk_next[{~cnt_reg[2:0], 3'b000} +: 8] = ebyte;
            cnt_next   = cnt_reg + 4'd1;
            okind_next = OUT_NET;
            ldata_next = '0;
            lok_next   = 1'b0;
            olast_next = elast;
            if (cnt_reg == 4'd7 || elast)
            begin
                ov_next = 1'b1;
            end
        end
    end

endmodule

// ===== bench/modbus_tcp_register_server_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_tcp_register_server_test
// Self-checking bench for the Modbus TCP register server: request frames and
// local register accesses go in as items, and a cycle-free model of the server
// predicts every response chunk and local reply, checked field by field.
// ----------------------------------------------------------------------------
module modbus_tcp_register_server_test;
    import mbtcp_pkg::*;

    localparam int NREGS    = 2048;
    localparam int IDLE_MAX = 20000;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  sbyte;
        logic [15:0] addr;
        logic [15:0] value;
        logic [3:0]  bidx;
        logic        bval;
    } req_item_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] chunk;
        logic [3:0]  nbytes;
        logic        last;
        logic [15:0] ldata;
        logic        lok;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // stream_byte, reg_address, reg_value, bit_index, bit_value
    logic [1:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // chunk_data, chunk_bytes, local_data, local_ok
    logic        m_tuser;   // kind
    logic        m_tlast;

    modbus_tcp_register_server uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    req_item_t   pending_items[$];
    reply_t      expected_replies[$];
    int          errors;
    int          sent;
    int          stalled_cycles;
    int          hold_cnt;
    bit          pressure_done;
    bit          stim_ready;
    bit          finished;
    int          phase;

    // server model state
    logic [15:0] regs [NREGS];
    int unsigned fpos;
    logic [15:0] tid, flen, first_w, second_w;
    logic [7:0]  unit_id, fcode, bcount, hi_byte;
    logic        wr_ok;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] reg_rd(int unsigned a);
        return (a < NREGS) ? regs[a] : 16'h0000;
    endfunction

    task automatic push_net(logic [7:0] rb [264], int unsigned total);
        int unsigned off, n;
        reply_t r;
        off = 0;
        while (off < total)
        begin
            n = (total - off > 8) ? 8 : total - off;
            r = '0;
            for (int j = 0; j < n; j++)
                r.chunk[63 - 8 * j -: 8] = rb[off + j];
            off += n;
            r.kind   = OUT_NET;
            r.nbytes = n[3:0];
            r.last   = (off >= total);
            expected_replies.push_back(r);
        end
    endtask

    task automatic serve_frame();
        logic [7:0]  rb [264];
        int unsigned size, p, plen;
        logic [15:0] v;
        size = 6 + flen;
        p = 7;
        if (size < 9)
            return;
        if (fcode == FC_READ_HOLD || fcode == FC_READ_INPUT)
        begin
            if (size < 12)
                return;
            if (second_w == 0 || second_w > READ_MAX)
            begin
                rb[p++] = fcode | EXC_FLAG;
                rb[p++] = EXC_BAD_VALUE;
            end
            else
            begin
                rb[p++] = fcode;
                rb[p++] = second_w[7:0] << 1;
                for (int i = 0; i < second_w; i++)
                begin
                    v = reg_rd((first_w + i) & 16'hFFFF);
                    rb[p++] = v[15:8];
                    rb[p++] = v[7:0];
                end
            end
        end
        else if (fcode == FC_WRITE_ONE || fcode == FC_WRITE_MANY)
        begin
            if (fcode == FC_WRITE_ONE)
            begin
                if (size < 12)
                    return;
                if (first_w < NREGS)
                    regs[first_w] = second_w;
            end
            else
            begin
                if (size < 13)
                    return;
                if (13 + bcount > size)
                    return;
            end
            rb[p++] = fcode;
            rb[p++] = first_w[15:8];
            rb[p++] = first_w[7:0];
            rb[p++] = second_w[15:8];
            rb[p++] = second_w[7:0];
        end
        else
        begin
            rb[p++] = fcode | EXC_FLAG;
            rb[p++] = EXC_BAD_FUNC;
        end
        plen = p - 6;
        rb[0] = tid[15:8];
        rb[1] = tid[7:0];
        rb[2] = 8'h00;
        rb[3] = 8'h00;
        rb[4] = plen[15:8];
        rb[5] = plen[7:0];
        rb[6] = unit_id;
        push_net(rb, p);
    endtask

    task automatic predict_server(req_item_t it);
        reply_t      r;
        int unsigned pos, wi, a;
        r = '0;
        if (it.func != IN_STREAM)
        begin
            a = 32'(it.addr);
            r.kind = OUT_LOCAL;
            if (a < NREGS)
            begin
                if (it.func == IN_WORD_WR)
                    regs[a] = it.value;
                else if (it.func == IN_BIT_WR)
                    regs[a][it.bidx] = it.bval;
                r.ldata = regs[a];
                r.lok   = 1'b1;
            end
            expected_replies.push_back(r);
            return;
        end
        pos = fpos;
        case (pos)
            0: begin tid[15:8] = it.sbyte; wr_ok = 1'b0; end
            1: tid[7:0] = it.sbyte;
            2, 3: ;
            4: flen = {it.sbyte, 8'h00};
            5: flen[7:0] = it.sbyte;
            6: unit_id = it.sbyte;
            7: fcode = it.sbyte;
            8: first_w = {it.sbyte, 8'h00};
            9: first_w[7:0] = it.sbyte;
            10: second_w = {it.sbyte, 8'h00};
            11: second_w[7:0] = it.sbyte;
            12:
            begin
                bcount = it.sbyte;
                wr_ok  = (13 + it.sbyte) <= (6 + flen);
            end
            default:
            begin
                if (((pos - 13) & 1) == 0)
                    hi_byte = it.sbyte;
                else
                begin
                    wi = (pos - 14) >> 1;
                    a  = (first_w + wi) & 16'hFFFF;
                    if (wr_ok && fcode == FC_WRITE_MANY && wi < second_w && a < NREGS)
                        regs[a] = {hi_byte, it.sbyte};
                end
            end
        endcase
        if (pos >= 5 && pos == 5 + flen)
        begin
            fpos = 0;
            serve_frame();
        end
        else
            fpos = pos + 1;
    endtask

    // ---------------- stimulus builders ----------------
    task automatic add_byte(logic [7:0] b);
        req_item_t it;
        it = '0;
        it.func  = IN_STREAM;
        it.sbyte = b;
        it.addr  = 16'($urandom);
        it.value = 16'($urandom);
        it.bidx  = 4'($urandom);
        it.bval  = 1'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_local(logic [1:0] f, logic [15:0] a, logic [15:0] v,
                             logic [3:0] bi, logic bv);
        req_item_t it;
        it.func  = f;
        it.sbyte = 8'($urandom);
        it.addr  = a;
        it.value = v;
        it.bidx  = bi;
        it.bval  = bv;
        pending_items.push_back(it);
    endtask

    // MBAP header plus pdu; pdu starts at the unit id, length is its size
    task automatic add_frame(logic [7:0] pdu[$]);
        logic [15:0] tr, ln;
        tr = 16'($urandom);
        ln = 16'(pdu.size());
        add_byte(tr[15:8]);
        add_byte(tr[7:0]);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        add_byte(ln[15:8]);
        add_byte(ln[7:0]);
        foreach (pdu[i])
            add_byte(pdu[i]);
    endtask

    // a negative byte count leaves the byte count field out
    task automatic add_request(logic [7:0] fc, logic [15:0] f1, logic [15:0] f2,
                               int nwords, int bc);
        logic [7:0] pdu[$];
        pdu = {};
        pdu.push_back(8'($urandom));
        pdu.push_back(fc);
        pdu.push_back(f1[15:8]);
        pdu.push_back(f1[7:0]);
        pdu.push_back(f2[15:8]);
        pdu.push_back(f2[7:0]);
        if (fc == FC_WRITE_MANY && bc >= 0)
        begin
            pdu.push_back(bc[7:0]);
            for (int i = 0; i < 2 * nwords; i++)
                pdu.push_back(8'($urandom));
        end
        add_frame(pdu);
    endtask

    task automatic add_short(int n);
        logic [7:0] pdu[$];
        pdu = {};
        for (int i = 0; i < n; i++)
            pdu.push_back(8'($urandom));
        add_frame(pdu);
    endtask

    task automatic add_random_request();
        int          sel, nw;
        logic [15:0] a;
        sel = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0: a = 16'($urandom);
            1: a = 16'(16'hFFFF - $urandom_range(0, 3));
            default: a = 16'($urandom_range(0, NREGS - 1));
        endcase
        if (sel < 6)
            add_request(($urandom_range(0, 1) != 0) ? FC_READ_HOLD : FC_READ_INPUT, a,
                        16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 8)),
                        0, 0);
        else if (sel < 9)
            add_request(FC_WRITE_ONE, a, 16'($urandom), 0, 0);
        else if (sel < 13)
        begin
            nw = $urandom_range(1, 4);
            add_request(FC_WRITE_MANY, a, 16'($urandom_range(0, 5)), nw,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 2 * nw);
        end
        else if (sel < 14)
            add_request(8'($urandom), a, 16'($urandom), 0, 0);
        else if (sel < 15)
            add_short($urandom_range(0, 6));
        else
            add_local(2'($urandom_range(1, 3)),
                      16'(($urandom_range(0, 3) == 0) ? $urandom
                                                     : $urandom_range(0, NREGS - 1)),
                      16'($urandom), 4'($urandom), 1'($urandom));
    endtask

    // ---------------- reset and stimulus ----------------
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        sent = 0;
        stalled_cycles = 0;
        hold_cnt = 0;
        pressure_done = 1'b0;
        stim_ready = 1'b0;
        finished = 1'b0;
        fpos = 0;
        tid = 0; flen = 0; first_w = 0; second_w = 0;
        unit_id = 0; fcode = 0; bcount = 0; hi_byte = 0; wr_ok = 0;
        foreach (regs[i])
            regs[i] = 16'h0000;

        // directed part
        add_local(IN_WORD_WR, 16'd5, 16'hFFFF, 4'd0, 1'b0);
        add_local(IN_BIT_WR, 16'd5, 16'h0000, 4'd15, 1'b0);
        add_local(IN_BIT_WR, 16'd6, 16'h0000, 4'd0, 1'b1);
        add_local(IN_WORD_RD, 16'd5, 16'h0000, 4'd0, 1'b0);
        add_local(IN_WORD_WR, 16'hFFFF, 16'h1234, 4'd3, 1'b1);
        add_local(IN_WORD_RD, 16'(NREGS - 1), 16'h0000, 4'd0, 1'b0);
        add_request(FC_READ_INPUT, 16'hFFFE, READ_MAX, 0, 0);    // wraps into the store
        add_request(FC_READ_HOLD, 16'd0, 16'd0, 0, 0);
        add_request(FC_READ_INPUT, 16'd0, 16'(READ_MAX + 16'd1), 0, 0);
        add_request(FC_WRITE_ONE, 16'(NREGS - 1), 16'hA55A, 0, 0);
        add_request(FC_WRITE_MANY, 16'd10, 16'd2, 3, 6);         // third word past quantity
        add_request(FC_WRITE_MANY, 16'd20, 16'd2, 2, 200);       // byte count past frame
        add_request(FC_WRITE_MANY, 16'd30, 16'd3, 3, 0);         // count does not limit writes
        add_request(8'hFF, 16'd0, 16'd0, 0, 0);
        add_short(0);
        add_short(2);
        add_request(FC_WRITE_MANY, 16'd0, 16'd0, 0, -1);         // short fc16 frame, 12 bytes

        while (pending_items.size() < 132)
            add_random_request();
        stim_ready = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idling phase follows progress through the item list
    always_comb
        phase = (sent / 32) % 4;

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (rst_n && stim_ready)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_server(pending_items.pop_front());
                sent <= sent + 1;
            end
            if (pending_items.size() != 0 &&
                ((s_tvalid && !s_tready) ||
                 !((phase == 1 && $urandom_range(0, 99) < 77) ||
                   (phase == 3 && $urandom_range(0, 99) < 8))))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].func;
                s_tdata  <= {3'b000, pending_items[0].bval, pending_items[0].bidx,
                             pending_items[0].value, pending_items[0].addr,
                             pending_items[0].sbyte};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    report("unexpected result", m_tdata[63:0], 64'd0);
                end
                else
                begin
                    r = expected_replies.pop_front();
                    if (m_tuser !== r.kind)
                        report("kind", 64'(m_tuser), 64'(r.kind));
                    if (m_tdata[63:0] !== r.chunk)
                        report("chunk_data", m_tdata[63:0], r.chunk);
                    if (m_tdata[67:64] !== r.nbytes)
                        report("chunk_bytes", 64'(m_tdata[67:64]), 64'(r.nbytes));
                    if (m_tlast !== r.last)
                        report("last", 64'(m_tlast), 64'(r.last));
                    if (m_tdata[83:68] !== r.ldata)
                        report("local_data", 64'(m_tdata[83:68]), 64'(r.ldata));
                    if (m_tdata[84] !== r.lok)
                        report("local_ok", 64'(m_tdata[84]), 64'(r.lok));
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && sent >= 40)
            begin
                pressure_done <= 1'b1;
                hold_cnt <= 600;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !((phase == 2 && $urandom_range(0, 99) < 77) ||
                              (phase == 3 && $urandom_range(0, 99) < 8));
        end
    end

    // ---------------- watchdog and end of run ----------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (!finished && stalled_cycles >= IDLE_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n && stim_ready);
        while (pending_items.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        finished = 1'b1;
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
